FILE: rtl/msort_pkg.sv
package msort_pkg;

  localparam int KEY_WIDTH = 32;
  localparam int MAX_KEYS  = 64;
  localparam int ADDR_W    = $clog2(MAX_KEYS);
  localparam int CNT_W     = $clog2(MAX_KEYS + 1);

  typedef logic [KEY_WIDTH-1:0] key_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_PREP,
    ST_MERGE,
    ST_EMIT
  } msort_state_e;

  typedef struct packed {
    logic load;   // accept key beats into the store
    logic prep;   // set up the next pass, or the emit walk
    logic merge;  // one merge step
    logic emit;   // walk the sorted store out
  } msort_cmd_t;

  typedef struct packed {
    logic load_last;  // beat carrying the final key taken this cycle
    logic sorted;     // run width covers the whole set
    logic pass_end;   // last write of the current pass
    logic emit_done;  // final result handed over
  } msort_status_t;

  // True if a must be placed after b.
  function automatic logic key_gt(key_t a, key_t b, logic sgn);
    key_t ta;
    key_t tb;
    ta = a;
    tb = b;
    ta[KEY_WIDTH-1] = a[KEY_WIDTH-1] ^ sgn;
    tb[KEY_WIDTH-1] = b[KEY_WIDTH-1] ^ sgn;
    return ta > tb;
  endfunction

endpackage

FILE: rtl/msort_ctrl.sv
module msort_ctrl
  import msort_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  msort_status_t status_i,
  output msort_cmd_t    cmd_o,
  output msort_state_e  state_o
);

  msort_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        if (status_i.load_last) state_d = ST_PREP;
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = status_i.sorted ? ST_EMIT : ST_MERGE;
      end
      ST_MERGE: begin
        cmd_o.merge = 1'b1;
        if (status_i.pass_end) state_d = ST_PREP;
      end
      ST_EMIT: begin
        cmd_o.emit = 1'b1;
        if (status_i.emit_done) state_d = ST_LOAD;
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  assign state_o = state_q;

endmodule

FILE: rtl/msort_dp.sv
module msort_dp
  import msort_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  msort_cmd_t    cmd_i,
  output msort_status_t status_o,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i,
  input  logic          in_valid_i,
  input  key_t          in_key_i,
  input  logic          in_last_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output key_t          out_key_o,
  output logic          out_last_o,
  output logic          out_ovf_o
);

  key_t mem_a [MAX_KEYS];
  key_t mem_b [MAX_KEYS];

  logic signed_q;
  cnt_t count_q, count_d;
  logic dropped_q, dropped_d;
  cnt_t width_q, width_d;
  logic src_sel_q, src_sel_d;
  cnt_t k_q, k_d;
  cnt_t l_q, l_d, r_q, r_d, mid_q, mid_d, hi_q, hi_d;
  logic valid_q, valid_d;
  logic last_q;
  key_t rd_l_q, rd_r_q;

  logic               load_beat, store_full, take_l, run_end, emit_adv;
  cnt_t               k_inc;
  logic [CNT_W:0]     run_mid, run_hi, first_mid, first_hi;
  logic [ADDR_W-1:0]  addr_l, addr_r, wr_addr;
  key_t               wr_data;
  logic               a_we, b_we, rd_en_l, rd_en_r;

  function automatic cnt_t clip(logic [CNT_W:0] v, cnt_t n);
    return (v > {1'b0, n}) ? n : v[CNT_W-1:0];
  endfunction

  assign load_beat  = cmd_i.load && in_valid_i;
  assign store_full = count_q == CNT_W'(MAX_KEYS);
  assign k_inc      = k_q + 1'b1;

  assign take_l  = (l_q < mid_q) && ((r_q >= hi_q) || !key_gt(rd_l_q, rd_r_q, signed_q));
  assign run_end = k_inc == hi_q;

  assign run_mid   = {1'b0, hi_q} + {1'b0, width_q};
  assign run_hi    = {1'b0, hi_q} + {width_q, 1'b0};
  assign first_mid = {1'b0, width_q};
  assign first_hi  = {width_q, 1'b0};

  assign emit_adv = cmd_i.emit && (k_q < count_q) && (!valid_q || out_ready_i);

  assign status_o.load_last = load_beat && in_last_i;
  assign status_o.sorted    = width_q >= count_q;
  assign status_o.pass_end  = cmd_i.merge && (k_inc == count_q);
  assign status_o.emit_done = cmd_i.emit && (k_q == count_q) && (!valid_q || out_ready_i);

  always_comb begin
    count_d   = count_q;
    dropped_d = dropped_q;
    width_d   = width_q;
    src_sel_d = src_sel_q;
    k_d       = k_q;
    l_d       = l_q;
    r_d       = r_q;
    mid_d     = mid_q;
    hi_d      = hi_q;
    valid_d   = valid_q;
    if (load_beat) begin
      if (store_full) dropped_d = 1'b1;
      else            count_d   = count_q + 1'b1;
    end
    if (cmd_i.prep) begin
      k_d = '0;
      if (!status_o.sorted) begin
        l_d   = '0;
        mid_d = clip(first_mid, count_q);
        hi_d  = clip(first_hi, count_q);
        r_d   = mid_d;
      end
    end
    if (cmd_i.merge) begin
      k_d = k_inc;
      if (run_end) begin
        l_d   = hi_q;
        mid_d = clip(run_mid, count_q);
        hi_d  = clip(run_hi, count_q);
        r_d   = mid_d;
      end else if (take_l) begin
        l_d = l_q + 1'b1;
      end else begin
        r_d = r_q + 1'b1;
      end
      if (status_o.pass_end) begin
        width_d   = {width_q[CNT_W-2:0], 1'b0};
        src_sel_d = !src_sel_q;
      end
    end
    if (cmd_i.emit) begin
      if (emit_adv) begin
        k_d     = k_inc;
        valid_d = 1'b1;
      end else if (out_ready_i) begin
        valid_d = 1'b0;
      end
      if (status_o.emit_done) begin
        count_d   = '0;
        dropped_d = 1'b0;
        width_d   = CNT_W'(1);
        src_sel_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      signed_q  <= 1'b1;
      count_q   <= '0;
      dropped_q <= 1'b0;
      width_q   <= CNT_W'(1);
      src_sel_q <= 1'b0;
      k_q       <= '0;
      valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) signed_q <= cfg_wdata_i;
      count_q   <= count_d;
      dropped_q <= dropped_d;
      width_q   <= width_d;
      src_sel_q <= src_sel_d;
      k_q       <= k_d;
      valid_q   <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    l_q   <= l_d;
    r_q   <= r_d;
    mid_q <= mid_d;
    hi_q  <= hi_d;
    if (emit_adv) last_q <= k_inc == count_q;
  end

  // Store ports: load fills A, merges write the side that is not the source.
  assign addr_l  = cmd_i.emit ? k_q[ADDR_W-1:0] : l_d[ADDR_W-1:0];
  assign addr_r  = r_d[ADDR_W-1:0];
  assign wr_addr = cmd_i.load ? count_q[ADDR_W-1:0] : k_q[ADDR_W-1:0];
  assign wr_data = cmd_i.load ? in_key_i : (take_l ? rd_l_q : rd_r_q);
  assign a_we    = (load_beat && !store_full) || (cmd_i.merge && src_sel_q);
  assign b_we    = cmd_i.merge && !src_sel_q;
  assign rd_en_l = cmd_i.prep || cmd_i.merge || emit_adv;
  assign rd_en_r = cmd_i.prep || cmd_i.merge;

  always_ff @(posedge clk_i) begin
    if (a_we) mem_a[wr_addr] <= wr_data;
    if (b_we) mem_b[wr_addr] <= wr_data;
    if (rd_en_l) rd_l_q <= src_sel_q ? mem_b[addr_l] : mem_a[addr_l];
    if (rd_en_r) rd_r_q <= src_sel_q ? mem_b[addr_r] : mem_a[addr_r];
  end

  assign out_valid_o = valid_q;
  assign out_key_o   = rd_l_q;
  assign out_last_o  = last_q;
  assign out_ovf_o   = dropped_q;

endmodule

FILE: rtl/merge_sorter_core.sv
// Merge sorter core.
// Keys arrive on the slave stream, one key per beat, tdata = key; the beat
// with tlast high closes the set. Up to MAX_KEYS keys are stored; further
// keys of the set are dropped and every result of that set carries
// tuser = overflow.
// Once the set is closed the store is sorted in ascending order by a
// bottom-up merge that ping-pongs between two key memories: each pass is a
// set-up step followed by a merge step per key, and ceil(log2 n) passes are run,
// all through the two registered read ports of the source memory.
// Results then leave on the master stream, one beat per cycle while the
// receiver takes them, tdata = key, tlast on the final key of the set.
// The slave side is ready only while a set is being loaded. A stalled
// receiver holds the output beat and pauses the emit walk.
// cfg_we_i/cfg_wdata_i write signed_compare (1 = two's complement order);
// write it only while the block is idle.
// Reset clears the key count, overflow flag and controller; signed_compare
// returns to 1. Memory contents are left as they are.
module merge_sorter_core
  import msort_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] key
  input  logic        s_axis_tlast,   // last_key
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] sorted_key
  output logic        m_axis_tlast,   // last_result
  output logic [0:0]  m_axis_tuser    // [0] overflow
);

  msort_cmd_t    cmd;
  msort_status_t status;
  msort_state_e  state;
  key_t          out_key;
  logic          out_ovf;

  // Sequencer: load, pass set-up, merge steps, emit walk.
  msort_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd),
    .state_o  (state)
  );

  // Key memories, merge heads and output register.
  msort_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_key_i    (KEY_WIDTH'(s_axis_tdata)),
    .in_last_i   (s_axis_tlast),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_key_o   (out_key),
    .out_last_o  (m_axis_tlast),
    .out_ovf_o   (out_ovf)
  );

  assign s_axis_tready = cmd.load;
  assign m_axis_tdata  = 32'(out_key);
  assign m_axis_tuser  = out_ovf;

  // Loading and emitting never overlap.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while results pending");

  // Closing beat of a set stops loading at once.
  a_close_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("still loading after final key");

  // The final result ends the set: nothing valid follows it.
  a_set_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
    else $error("result after final key");

  // Merging happens only with the slave side closed and no result valid.
  a_merge_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state == ST_MERGE) |-> (!s_axis_tready && !m_axis_tvalid))
    else $error("stream active during merge");

endmodule

FILE: verif/tb_merge_sorter_core.sv
module tb_merge_sorter_core;
  import msort_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int IDLE_LIMIT     = 5000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int SMALL_PER_PHASE = 1;
  localparam bit ORDER_SIGNED   = 1'b1;
  localparam bit ORDER_UNSIGNED = 1'b0;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [31:0] key
  logic        s_axis_tlast;   // last_key
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [31:0] sorted_key
  logic        m_axis_tlast;   // last_result
  logic [0:0]  m_axis_tuser;   // [0] overflow

  // Expected sorted output: collects up to MAX_KEYS keys of the open set and,
  // on the closing beat, queues the stored keys in ascending order.
  class sort_scoreboard;
    key_t set_keys[$];
    bit   dropped;
    bit   signed_order;
    key_t exp_key[$];
    bit   exp_last[$];
    bit   exp_ovf[$];
    int   mismatches;

    function new();
      signed_order = 1'b1;
      dropped      = 1'b0;
      mismatches   = 0;
    endfunction

    function void set_order(bit s);
      signed_order = s;
    endfunction

    function bit placed_after(key_t a, key_t b);
      if (signed_order) return $signed(a) > $signed(b);
      return a > b;
    endfunction

    function void note_key(key_t k, bit lst);
      key_t ordered[MAX_KEYS];
      int   n;
      int   pos;
      if (set_keys.size() < MAX_KEYS) set_keys.push_back(k);
      else dropped = 1'b1;
      if (!lst) return;
      // insertion sort; equal keys are identical bit patterns
      n = 0;
      foreach (set_keys[i]) begin
        pos = n;
        while (pos > 0 && placed_after(ordered[pos-1], set_keys[i])) begin
          ordered[pos] = ordered[pos-1];
          pos--;
        end
        ordered[pos] = set_keys[i];
        n++;
      end
      for (int i = 0; i < n; i++) begin
        exp_key.push_back(ordered[i]);
        exp_last.push_back(i == n - 1);
        exp_ovf.push_back(dropped);
      end
      set_keys.delete();
      dropped = 1'b0;
    endfunction

    function void check_result(logic [31:0] d, logic l, logic u);
      key_t ek;
      bit   el;
      bit   eo;
      if (exp_key.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected sorted beat: key %h last %b ovf %b", d, l, u);
        return;
      end
      ek = exp_key.pop_front();
      el = exp_last.pop_front();
      eo = exp_ovf.pop_front();
      if (d !== ek || l !== el || u !== eo) begin
        mismatches++;
        if (mismatches <= 10)
          $display("sorted beat mismatch: expected key %h last %b ovf %b, got key %h last %b ovf %b",
                   ek, el, eo, d, l, u);
      end
    endfunction

    function int pending();
      return exp_key.size();
    endfunction
  endclass

  sort_scoreboard sb;
  int   burst_left;
  int   idle_cycles;
  int   rx_left;
  int   rx_mode;
  int   rx_tick;
  key_t prev_key;

  merge_sorter_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Receiver: switch between stall patterns, picking a new one at random.
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(16, 96);
    end else begin
      rx_left--;
    end
    rx_tick++;
    case (rx_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= (rx_tick % 3 == 0);
      default: m_axis_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Check every output beat taken by the receiver.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
  end

  // Watchdog: end the run if no beat moves on either side for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("tb_merge_sorter_core: FAIL");
      $finish;
    end
  end

  // Entered and left at a falling edge.
  task automatic write_order(input bit s);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= s;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_order(s);
  endtask

  // Offer one key beat, holding it until taken; between bursts, a gap is inserted at random.
  task automatic send_key(input key_t k, input bit lst);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 16);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= k;
    s_axis_tlast  <= lst;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_key(k, lst);
    burst_left--;
    @(negedge clk_i);
  endtask

  function automatic key_t rand_key();
    key_t k;
    case ($urandom_range(0, 5))
      0: k = $urandom_range(0, 15);
      1: k = 32'hFFFF_FFF0 + $urandom_range(0, 15);
      2: k = 32'h7FFF_FFF8 + $urandom_range(0, 15);
      3: k = prev_key;
      default: k = $urandom;
    endcase
    prev_key = k;
    return k;
  endfunction

  task automatic send_set(input int n);
    for (int i = 0; i < n; i++) send_key(rand_key(), i == n - 1);
  endtask

  function automatic key_t extreme_key(input int i);
    case (i)
      0: return 32'hFFFF_FFFF;
      1: return 32'h0000_0000;
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      4: return 32'h0000_0001;
      5: return 32'h8000_0001;
      6: return 32'h7FFF_FFFE;
      default: return 32'hFFFF_FFFE;
    endcase
  endfunction

  // Wait for every sorted beat, drop tvalid and let the core settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    int left;
    int n;
    sb            = new();
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    burst_left    = 0;
    idle_cycles   = 0;
    prev_key      = '0;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: single-key set, extremes around the sign boundary, duplicates.
    write_order(ORDER_SIGNED);
    send_key(32'h0000_0005, 1'b1);
    for (int i = 0; i < 8; i++) send_key(extreme_key(i), i == 7);
    send_key(32'hA5A5_A5A5, 1'b0);
    send_key(32'h0000_0003, 1'b0);
    send_key(32'hA5A5_A5A5, 1'b0);
    send_key(32'h0000_0003, 1'b1);
    drain();

    write_order(ORDER_UNSIGNED);
    for (int i = 0; i < 8; i++) send_key(extreme_key(i), i == 7);
    send_key(32'h8000_0000, 1'b0);
    send_key(32'h7FFF_FFFF, 1'b1);
    drain();

    // Random: mostly short sets, one set past capacity.
    for (int ph = 0; ph < 4; ph++) begin
      if (ph < 2) write_order(ph[0] ? ORDER_UNSIGNED : ORDER_SIGNED);
      else write_order(1'($urandom_range(0, 1)));
      if (ph == 1) send_set($urandom_range(MAX_KEYS + 1, MAX_KEYS + 2));
      left = SMALL_PER_PHASE;
      while (left > 0) begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
        send_set(n);
        left -= n;
      end
      drain();
    end

    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("tb_merge_sorter_core: PASS");
    else
      $display("tb_merge_sorter_core: FAIL");
    $finish;
  end

endmodule
